// ----- rtl/core/imu_pitch_complementary_filter_top_assert.svh -----
// Assertion macros for the pitch filter core.
`ifndef IMU_PITCH_COMPLEMENTARY_FILTER_TOP_ASSERT_SVH
`define IMU_PITCH_COMPLEMENTARY_FILTER_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define IPCF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define IPCF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/ipcf_pkg.sv -----
// Shared types, widths, register codes and the CORDIC arctangent table.
`timescale 1ns / 1ps
package ipcf_pkg;

   // Field widths
   localparam int SAMPLE_W   = 16;
   localparam int ANGLE_W    = 17;
   localparam int SP_W       = 12;
   localparam int WEIGHT_W   = 17;
   localparam int GGAIN_W    = 24;
   localparam int SGAIN_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // Datapath widths
   localparam int XY_W      = 20;
   localparam int Z_W       = 26;
   localparam int DIFF_W    = 42;
   localparam int LO_W      = 21;
   localparam int MUL_OP_W  = 26;
   localparam int MUL_W     = 2 * MUL_OP_W;
   localparam int ACC_W     = 60;
   localparam int RND_SHIFT = 32;
   localparam int A_FULL_W  = ACC_W - RND_SHIFT;
   localparam int MAG_W     = 16;
   localparam int TAB_IDX_W = 5;

   localparam int IPCF_CORDIC_STEPS_DEF = 16;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [ANGLE_W-1:0]  angle_type;
   typedef logic [SP_W-1:0]            setpoint_type;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_WEIGHT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_GAIN     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SETPOINT_GAIN = 2'd2;

   // Register reset values
   localparam logic [WEIGHT_W-1:0] BLEND_WEIGHT_RST  = 17'd2621;
   localparam logic [GGAIN_W-1:0]  GYRO_GAIN_RST     = 24'd25614;
   localparam logic [SGAIN_W-1:0]  SETPOINT_GAIN_RST = 16'd5824;

   localparam logic [WEIGHT_W-1:0]   WEIGHT_ONE = 17'd65536;
   localparam angle_type             ANGLE_MAX  = 17'sd46080;
   localparam logic signed [Z_W-1:0] Z_QUARTER  = 26'sd5898240;
   localparam logic [SP_W-1:0]       SP_MAX     = 12'd4095;

   // atan(2^-i) in Q10.16 degrees
   function automatic logic signed [Z_W-1:0] atan_deg_q16(input logic [TAB_IDX_W-1:0] idx);
      logic signed [Z_W-1:0] val;
      case (idx)
         5'd0:    val = 26'sd2949120;
         5'd1:    val = 26'sd1740967;
         5'd2:    val = 26'sd919879;
         5'd3:    val = 26'sd466945;
         5'd4:    val = 26'sd234379;
         5'd5:    val = 26'sd117304;
         5'd6:    val = 26'sd58666;
         5'd7:    val = 26'sd29335;
         5'd8:    val = 26'sd14668;
         5'd9:    val = 26'sd7334;
         5'd10:   val = 26'sd3667;
         5'd11:   val = 26'sd1833;
         5'd12:   val = 26'sd917;
         5'd13:   val = 26'sd458;
         5'd14:   val = 26'sd229;
         5'd15:   val = 26'sd115;
         5'd16:   val = 26'sd57;
         5'd17:   val = 26'sd29;
         5'd18:   val = 26'sd14;
         5'd19:   val = 26'sd7;
         5'd20:   val = 26'sd4;
         5'd21:   val = 26'sd2;
         5'd22:   val = 26'sd1;
         default: val = 26'sd0;
      endcase
      return val;
   endfunction

endpackage

// ----- rtl/core/ipcf_if.sv -----
// Valid/ready channel interfaces for IMU samples and filter results.
`timescale 1ns / 1ps
interface ipcf_req_if;
   import ipcf_pkg::*;
   logic       valid;
   logic       ready;
   sample_type accel_x;
   sample_type accel_z;
   sample_type gyro_y;
   modport source (output valid, accel_x, accel_z, gyro_y, input ready);
   modport sink   (input valid, accel_x, accel_z, gyro_y, output ready);
endinterface

interface ipcf_rsp_if;
   import ipcf_pkg::*;
   logic         valid;
   logic         ready;
   angle_type    pitch_angle;
   setpoint_type drive_setpoint;
   modport source (output valid, pitch_angle, drive_setpoint, input ready);
   modport sink   (input valid, pitch_angle, drive_setpoint, output ready);
endinterface

// ----- rtl/core/imu_pitch_complementary_filter_top.sv -----
// Pitch complementary filter: CORDIC atan2 of the accelerometer blended with the gyro angle.
//
// One IMU sample is taken per transaction on req_if and one result leaves per
// transaction on rsp_if. A sample runs CORDIC_STEPS iterations of the shift-add
// CORDIC loop (one iteration a cycle through one set of barrel shifters and
// adders), then steps on one shared 26x26 multiplier and its adders (gyro
// scale, difference, two blend partial products, round and saturate, setpoint
// scale, result load); the result load waits until the output register is
// free. A new sample is accepted only after the previous result is loaded.
// req_if.ready is high while the core is idle; a result waiting in the output
// register does not block the next sample. Registers are written through
// csr_write_en/csr_index/csr_write_data; the user must write them only while
// no sample is in flight, as the block itself does not enforce it. Unknown
// indexes are ignored.
`timescale 1ns / 1ps
module imu_pitch_complementary_filter_top #(
   parameter int CORDIC_STEPS = ipcf_pkg::IPCF_CORDIC_STEPS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   ipcf_req_if.sink                        req_if,
   ipcf_rsp_if.source                      rsp_if,
   input  logic                            csr_write_en,
   input  logic [ipcf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ipcf_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import ipcf_pkg::*;

`include "imu_pitch_complementary_filter_top_assert.svh"

   localparam int STEP_W = $clog2(CORDIC_STEPS);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

   // Sequencer states
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_CORDIC = 4'd1;
   localparam logic [3:0] ST_GYRO   = 4'd2;
   localparam logic [3:0] ST_DIFF   = 4'd3;
   localparam logic [3:0] ST_MHI    = 4'd4;
   localparam logic [3:0] ST_MLO    = 4'd5;
   localparam logic [3:0] ST_ROUND  = 4'd6;
   localparam logic [3:0] ST_SP     = 4'd7;
   localparam logic [3:0] ST_FIN    = 4'd8;

   localparam logic signed [ACC_W-1:0]    ROUND_HALF = ACC_W'(64'sd1 <<< (RND_SHIFT - 1));
   localparam logic signed [A_FULL_W-1:0] RND_MAX    = A_FULL_W'(ANGLE_MAX);

   // Control state
   logic [3:0]          state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                zero_ff, zero_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WEIGHT_W-1:0] blend_ff, blend_in;
   logic [GGAIN_W-1:0]  ggain_ff, ggain_in;
   logic [SGAIN_W-1:0]  sgain_ff, sgain_in;
   angle_type           angle_ff, angle_in;

   // Datapath
   logic signed [XY_W-1:0]   x_ff, x_in;
   logic signed [XY_W-1:0]   y_ff, y_in;
   logic signed [Z_W-1:0]    z_ff, z_in;
   sample_type               gy_ff, gy_in;
   logic signed [MUL_W-1:0]  mul_ff, mul_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   angle_type                pitch_ff, pitch_in;
   setpoint_type             sp_ff, sp_in;

   // Shared-unit signals
   logic signed [XY_W-1:0]     ax_ext, az_ext, dx, dy;
   logic signed [Z_W-1:0]      tab_val;
   logic                       mul_en;
   logic signed [MUL_OP_W-1:0] mul_a, mul_b;
   logic [WEIGHT_W-1:0]        w_clamp;
   logic signed [ANGLE_W-1:0]  angle_neg;
   logic [MAG_W-1:0]           mag;
   logic signed [ACC_W-1:0]    rnd_sum;
   logic signed [A_FULL_W-1:0] a_full;
   logic [MAG_W-1:0]           sp_full;
   logic                       out_free;

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.pitch_angle = pitch_ff;
   assign rsp_if.drive_setpoint = sp_ff;

   assign ax_ext   = XY_W'(req_if.accel_x);
   assign az_ext   = XY_W'(req_if.accel_z);
   assign dx       = y_ff >>> step_ff;
   assign dy       = x_ff >>> step_ff;
   assign tab_val  = atan_deg_q16(TAB_IDX_W'(step_ff));
   assign w_clamp  = (blend_ff > WEIGHT_ONE) ? WEIGHT_ONE : blend_ff;
   assign angle_neg = -angle_ff;
   assign mag      = angle_ff[ANGLE_W-1] ? MAG_W'(angle_neg) : MAG_W'(angle_ff);
   assign rnd_sum  = acc_ff + ACC_W'(mul_ff);
   assign a_full   = rnd_sum[ACC_W-1:RND_SHIFT];
   assign sp_full  = mul_ff[2*MAG_W-1:MAG_W];
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // Select the multiplier operands for the current step
   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         ST_GYRO: begin
            mul_a = MUL_OP_W'(gy_ff);
            mul_b = $signed({{(MUL_OP_W-GGAIN_W){1'b0}}, ggain_ff});
         end
         ST_MHI: begin
            mul_a = $signed({{(MUL_OP_W-WEIGHT_W){1'b0}}, w_clamp});
            mul_b = MUL_OP_W'($signed(diff_ff[DIFF_W-1:LO_W]));
         end
         ST_MLO: begin
            mul_a = $signed({{(MUL_OP_W-WEIGHT_W){1'b0}}, w_clamp});
            mul_b = $signed({{(MUL_OP_W-LO_W){1'b0}}, diff_ff[LO_W-1:0]});
         end
         ST_SP: begin
            mul_a = $signed({{(MUL_OP_W-MAG_W){1'b0}}, mag});
            mul_b = $signed({{(MUL_OP_W-SGAIN_W){1'b0}}, sgain_ff});
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   // Sequencer and next-state datapath
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff;
      blend_in     = blend_ff;
      ggain_in     = ggain_ff;
      sgain_in     = sgain_ff;
      angle_in     = angle_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      gy_in        = gy_ff;
      mul_in       = mul_en ? (MUL_W'(mul_a) * MUL_W'(mul_b)) : mul_ff;
      diff_in      = diff_ff;
      acc_in       = acc_ff;
      pitch_in     = pitch_ff;
      sp_in        = sp_ff;

      // Drop the result once the sink takes it
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Register writes
      if (csr_write_en) begin
         case (csr_index)
            CSR_BLEND_WEIGHT:  blend_in = csr_write_data[WEIGHT_W-1:0];
            CSR_GYRO_GAIN:     ggain_in = csr_write_data[GGAIN_W-1:0];
            CSR_SETPOINT_GAIN: sgain_in = csr_write_data[SGAIN_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            // Take a sample and pre-rotate into the right half plane
            if (req_if.valid) begin
               gy_in    = req_if.gyro_y;
               zero_in  = (req_if.accel_x == '0) && (req_if.accel_z == '0);
               step_in  = '0;
               state_in = ST_CORDIC;
               if (req_if.accel_z[SAMPLE_W-1]) begin
                  if (!req_if.accel_x[SAMPLE_W-1]) begin
                     x_in = ax_ext;
                     y_in = -az_ext;
                     z_in = Z_QUARTER;
                  end else begin
                     x_in = -ax_ext;
                     y_in = az_ext;
                     z_in = -Z_QUARTER;
                  end
               end else begin
                  x_in = az_ext;
                  y_in = ax_ext;
                  z_in = '0;
               end
            end
         end
         ST_CORDIC: begin
            // One vectoring iteration a cycle
            if (!y_ff[XY_W-1]) begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               if (!zero_ff) z_in = z_ff + tab_val;
            end else begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               if (!zero_ff) z_in = z_ff - tab_val;
            end
            if (step_ff == STEP_LAST) begin
               step_in  = '0;
               state_in = ST_GYRO;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_GYRO: begin
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            // Propagated angle minus accelerometer pitch, both in Q.24
            diff_in  = (DIFF_W'(angle_ff) <<< 16) + DIFF_W'(mul_ff) - (DIFF_W'(z_ff) <<< 8);
            state_in = ST_MHI;
         end
         ST_MHI: begin
            state_in = ST_MLO;
         end
         ST_MLO: begin
            // Collect the high partial product, the accel term and the rounding half
            acc_in   = (ACC_W'(mul_ff) <<< LO_W) + (ACC_W'(z_ff) <<< 24) + ROUND_HALF;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            // Add the low partial product, round to Q9.8 and saturate
            if (a_full > RND_MAX) begin
               angle_in = ANGLE_MAX;
            end else if (a_full < -RND_MAX) begin
               angle_in = -ANGLE_MAX;
            end else begin
               angle_in = ANGLE_W'(a_full);
            end
            state_in = ST_SP;
         end
         ST_SP: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // Load the output register when it is free
            if (out_free) begin
               pitch_in     = angle_ff;
               sp_in        = (sp_full > MAG_W'(SP_MAX)) ? SP_MAX : SP_W'(sp_full);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         zero_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         blend_ff     <= BLEND_WEIGHT_RST;
         ggain_ff     <= GYRO_GAIN_RST;
         sgain_ff     <= SETPOINT_GAIN_RST;
         angle_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         zero_ff      <= zero_in;
         rsp_valid_ff <= rsp_valid_in;
         blend_ff     <= blend_in;
         ggain_ff     <= ggain_in;
         sgain_ff     <= sgain_in;
         angle_ff     <= angle_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      gy_ff    <= gy_in;
      mul_ff   <= mul_in;
      diff_ff  <= diff_in;
      acc_ff   <= acc_in;
      pitch_ff <= pitch_in;
      sp_ff    <= sp_in;
   end

   `IPCF_ASSERT_NEXT(a_accept_starts_cordic, clock, reset,
      req_if.valid && req_if.ready, state_ff == ST_CORDIC,
      "accepted sample did not start the CORDIC loop")
   `IPCF_ASSERT_NOW(a_angle_in_range, clock, reset,
      1'b1, (angle_ff <= ANGLE_MAX) && (angle_ff >= -ANGLE_MAX),
      "stored angle outside +/-180 degrees")
   `IPCF_ASSERT_NOW(a_step_idle_zero, clock, reset,
      state_ff != ST_CORDIC, step_ff == '0,
      "iteration counter not cleared outside the CORDIC loop")
   `IPCF_ASSERT_NEXT(a_fin_loads_result, clock, reset,
      (state_ff == ST_FIN) && out_free,
      rsp_valid_ff && (state_ff == ST_IDLE) && (rsp_if.pitch_angle == angle_ff),
      "finished sample not loaded into the result register")

endmodule
